### hdl/fpim_pkg.sv
// shared types and constants of the four point impedance meter
`timescale 1ns / 1ps
package fpim_pkg;

    localparam int ADC_W     = 12;
    localparam int SUM_W     = 22;
    localparam int CNT_W     = 11;
    localparam int MAX_SETS  = 1024;
    localparam int IQ_W      = 13;
    localparam int POW_W     = 26;
    localparam int ANG_W     = 31;
    localparam int ANG_FRAC  = 28;
    localparam int ANUM_W    = 42;
    localparam int ADEN_W    = 14;
    localparam int RNUM_W    = 58;
    localparam int ROOT_W    = 29;
    localparam int MAG_W     = 32;
    localparam int PH_W      = 16;
    localparam logic [29:0] HALF_PI_Q29 = 30'd843314857;

    typedef struct packed {
        logic             sample_en;
        logic [1:0]       pos;
        logic             add_set;
        logic             start;
        logic             clear;
    } t_lane_ctl;

    typedef struct packed {
        logic [POW_W-1:0]        pow;
        logic signed [ANG_W-1:0] ang;
    } t_lane_res;

    typedef enum logic [1:0] {LN_IDLE, LN_AVG, LN_POW, LN_ANG} t_lane_st;
    typedef enum logic [1:0] {MG_IDLE, MG_DIV, MG_SQRT, MG_DONE} t_merge_st;
    typedef enum logic [2:0] {ST_ACC, ST_LAUNCH, ST_LANE, ST_MERGE, ST_HOLD} t_top_st;

endpackage

### hdl/fpim_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module fpim_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] n_rem;
    logic             n_bit;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_quot[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_diff[DEN_W-1:0];
            n_bit = 1'b1;
        end else begin
            n_rem = w_trial[DEN_W-1:0];
            n_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[NUM_W-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### hdl/fpim_sqrt.sv
// integer square root, one root bit per cycle
`timescale 1ns / 1ps
module fpim_sqrt #(
    parameter int IN_W = 58
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_val,
    output logic              o_done,
    output logic [IN_W/2-1:0] o_root
);
    localparam int RT_W  = IN_W / 2;
    localparam int REM_W = RT_W + 2;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [IN_W-1:0]  r_x;
    logic [RT_W-1:0]  r_root;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] n_rem;
    logic             n_bit;
    logic [REM_W+1:0] w_trial;
    logic [REM_W+1:0] w_test;
    logic [REM_W+1:0] w_diff;

    always_comb begin
        w_trial = {r_rem, r_x[IN_W-1:IN_W-2]};
        w_test  = {2'b00, r_root, 2'b01};
        w_diff  = w_trial - w_test;
        if (w_trial >= w_test) begin
            n_rem = w_diff[REM_W-1:0];
            n_bit = 1'b1;
        end else begin
            n_rem = w_trial[REM_W-1:0];
            n_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_val;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[IN_W-3:0], 2'b00};
            r_root <= {r_root[RT_W-2:0], n_bit};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### hdl/fpim_lane.sv
// one channel lane: position sums, averages, i/q power and angle
`timescale 1ns / 1ps
module fpim_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fpim_pkg::t_lane_ctl          i_ctl,
    input  logic [fpim_pkg::ADC_W-1:0]   i_sample,
    input  logic [fpim_pkg::CNT_W-1:0]   i_set_count,
    output logic                         o_done,
    output fpim_pkg::t_lane_res          o_res
);
    fpim_pkg::t_lane_st r_st, n_st;

    logic [fpim_pkg::ADC_W-1:0]  r_pend [3];
    logic [fpim_pkg::SUM_W-1:0]  r_sum  [4];
    logic [fpim_pkg::SUM_W-1:0]  w_avg  [4];
    logic [3:0]                  w_avg_done;
    logic signed [fpim_pkg::IQ_W-1:0] r_i, r_q;
    logic [fpim_pkg::POW_W-1:0]  r_pow;
    logic signed [fpim_pkg::ANG_W-1:0] r_ang;
    logic                        r_neg, r_zero;
    logic                        r_done;
    logic [fpim_pkg::IQ_W-1:0]   w_ay, w_ax;
    logic [fpim_pkg::ADEN_W-1:0] w_top, w_den;
    logic [fpim_pkg::ANUM_W-1:0] w_num;
    logic [fpim_pkg::ANUM_W-1:0] w_quot;
    logic signed [fpim_pkg::ANG_W-1:0] w_qang;
    logic                        w_ang_start, w_ang_done;
    logic signed [2*fpim_pkg::IQ_W-1:0] w_ii, w_qq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) begin
                r_sum[j] <= '0;
            end
        end else if (i_ctl.clear) begin
            for (int j = 0; j < 4; j++) begin
                r_sum[j] <= '0;
            end
        end else if (i_ctl.sample_en && i_ctl.add_set) begin
            for (int j = 0; j < 3; j++) begin
                r_sum[j] <= r_sum[j] + fpim_pkg::SUM_W'(r_pend[j]);
            end
            r_sum[3] <= r_sum[3] + fpim_pkg::SUM_W'(i_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sample_en && i_ctl.pos != 2'd3) begin
            r_pend[i_ctl.pos] <= i_sample;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_avg
        fpim_div #(.NUM_W(fpim_pkg::SUM_W), .DEN_W(fpim_pkg::CNT_W)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (i_ctl.start),
            .i_num   (r_sum[g]),
            .i_den   (i_set_count),
            .o_done  (w_avg_done[g]),
            .o_quot  (w_avg[g])
        );
    end

    // linear atan2 with y = i, x = q
    always_comb begin
        w_ay  = r_i[fpim_pkg::IQ_W-1] ? fpim_pkg::IQ_W'(-r_i) : r_i;
        w_ax  = r_q[fpim_pkg::IQ_W-1] ? fpim_pkg::IQ_W'(-r_q) : r_q;
        w_den = fpim_pkg::ADEN_W'(w_ay) + fpim_pkg::ADEN_W'(w_ax);
        if (r_q[fpim_pkg::IQ_W-1]) begin
            w_top = fpim_pkg::ADEN_W'(w_ay) + {w_ax, 1'b0};
        end else begin
            w_top = fpim_pkg::ADEN_W'(w_ay);
        end
        w_num = {w_top, {fpim_pkg::ANG_FRAC{1'b0}}};
        w_ii  = r_i * r_i;
        w_qq  = r_q * r_q;
        w_qang = $signed({1'b0, w_quot[fpim_pkg::ANG_W-2:0]});
    end

    fpim_div #(.NUM_W(fpim_pkg::ANUM_W), .DEN_W(fpim_pkg::ADEN_W)) u_ang_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ang_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_ang_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            fpim_pkg::LN_IDLE: if (i_ctl.start) n_st = fpim_pkg::LN_AVG;
            fpim_pkg::LN_AVG:  if (&w_avg_done) n_st = fpim_pkg::LN_POW;
            fpim_pkg::LN_POW:  n_st = fpim_pkg::LN_ANG;
            fpim_pkg::LN_ANG:  if (w_ang_done) n_st = fpim_pkg::LN_IDLE;
            default:           n_st = fpim_pkg::LN_IDLE;
        endcase
    end

    always_comb begin
        w_ang_start = (r_st == fpim_pkg::LN_POW);
        o_done      = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= fpim_pkg::LN_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == fpim_pkg::LN_ANG) && w_ang_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == fpim_pkg::LN_AVG && (&w_avg_done)) begin
            r_i <= $signed({1'b0, w_avg[0][fpim_pkg::ADC_W-1:0]})
                 - $signed({1'b0, w_avg[2][fpim_pkg::ADC_W-1:0]});
            r_q <= $signed({1'b0, w_avg[1][fpim_pkg::ADC_W-1:0]})
                 - $signed({1'b0, w_avg[3][fpim_pkg::ADC_W-1:0]});
        end
        if (r_st == fpim_pkg::LN_POW) begin
            r_pow  <= fpim_pkg::POW_W'(w_ii) + fpim_pkg::POW_W'(w_qq);
            r_neg  <= r_i[fpim_pkg::IQ_W-1];
            r_zero <= (r_i == '0) && (r_q == '0);
        end
        if (r_st == fpim_pkg::LN_ANG && w_ang_done) begin
            if (r_zero) begin
                r_ang <= '0;
            end else if (r_neg) begin
                r_ang <= -w_qang;
            end else begin
                r_ang <= w_qang;
            end
        end
    end

    assign o_res.pow = r_pow;
    assign o_res.ang = r_ang;

endmodule

### hdl/fpim_merge.sv
// merge of the two lanes: magnitude ratio, square root and phase difference
`timescale 1ns / 1ps
module fpim_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  fpim_pkg::t_lane_res               i_cur,
    input  fpim_pkg::t_lane_res               i_vol,
    output logic                              o_done,
    output logic [fpim_pkg::MAG_W-1:0]        o_mag,
    output logic signed [fpim_pkg::PH_W-1:0]  o_phase
);
    fpim_pkg::t_merge_st r_st, n_st;

    logic                         r_zero;
    logic signed [31:0]           r_diff;
    logic signed [31:0]           w_wrap;
    logic [29:0]                  r_dmag;
    logic                         r_dneg;
    logic [59:0]                  r_prod;
    logic [60:0]                  w_round;
    logic [fpim_pkg::PH_W-1:0]    w_pmag;
    logic                         w_div_start, w_div_done, w_sq_start, w_sq_done;
    logic [fpim_pkg::RNUM_W-1:0]  w_quot;
    logic [fpim_pkg::ROOT_W-1:0]  w_root;

    fpim_div #(.NUM_W(fpim_pkg::RNUM_W), .DEN_W(fpim_pkg::POW_W)) u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({i_vol.pow, 32'd0}),
        .i_den   (i_cur.pow),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    fpim_sqrt #(.IN_W(fpim_pkg::RNUM_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (w_quot),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_comb begin
        if (r_diff > 32'sd536870912) begin
            w_wrap = r_diff - 32'sd1073741824;
        end else if (r_diff < -32'sd536870912) begin
            w_wrap = r_diff + 32'sd1073741824;
        end else begin
            w_wrap = r_diff;
        end
        w_round = {1'b0, r_prod} + (61'd1 << 43);
        w_pmag  = w_round[59:44];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            fpim_pkg::MG_IDLE: begin
                if (i_start) begin
                    n_st = (i_cur.pow == '0) ? fpim_pkg::MG_DONE : fpim_pkg::MG_DIV;
                end
            end
            fpim_pkg::MG_DIV:  if (w_div_done) n_st = fpim_pkg::MG_SQRT;
            fpim_pkg::MG_SQRT: if (w_sq_done) n_st = fpim_pkg::MG_DONE;
            fpim_pkg::MG_DONE: n_st = fpim_pkg::MG_IDLE;
            default:           n_st = fpim_pkg::MG_IDLE;
        endcase
    end

    always_comb begin
        w_div_start = (r_st == fpim_pkg::MG_IDLE) && i_start && (i_cur.pow != '0);
        w_sq_start  = (r_st == fpim_pkg::MG_DIV) && w_div_done;
        o_done      = (r_st == fpim_pkg::MG_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= fpim_pkg::MG_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == fpim_pkg::MG_IDLE && i_start) begin
            r_zero <= (i_cur.pow == '0);
            r_diff <= 32'(i_vol.ang) - 32'(i_cur.ang);
        end
        r_dneg <= w_wrap[31];
        r_dmag <= w_wrap[31] ? 30'(-w_wrap) : w_wrap[29:0];
        r_prod <= r_dmag * fpim_pkg::HALF_PI_Q29;
    end

    assign o_mag   = r_zero ? '0 : fpim_pkg::MAG_W'(w_root);
    assign o_phase = r_zero ? '0 : (r_dneg ? -$signed(w_pmag) : $signed(w_pmag));

endmodule

### hdl/four_point_impedance_meter.sv
// top level of the four point impedance meter
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   current, voltage, tlast = last pair
// m_axis    out  m_axis_tvalid/m_axis_tready   magnitude q16.16, phase q3.13
// cfg       in   i_cfg_wr_en                   enable
// one sample pair per cycle while accumulating
// after the last pair input is held through the averaging dividers and the
// angle divider in each lane, then the 58-step ratio divider and 29-step root
// synchronous active-low reset clears control, sums and enable
// a finished result waits in the output register while new pairs are taken
`timescale 1ns / 1ps
module four_point_impedance_meter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // current_sample, voltage_sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // impedance_magnitude, impedance_phase
);
    fpim_pkg::t_top_st r_st, n_st;

    logic                        r_enable;
    logic [1:0]                  r_pos;
    logic [fpim_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_out_valid;
    logic [fpim_pkg::MAG_W-1:0]  r_mag;
    logic [fpim_pkg::PH_W-1:0]   r_phase;
    logic                        w_acc, w_add, w_load, w_mstart;
    fpim_pkg::t_lane_ctl         w_ctl;
    fpim_pkg::t_lane_res         w_res_c, w_res_v;
    logic                        w_done_c, w_done_v, w_mdone;
    logic [fpim_pkg::MAG_W-1:0]  w_mag;
    logic signed [fpim_pkg::PH_W-1:0] w_phase;

    always_comb begin
        w_acc = s_axis_tvalid && s_axis_tready && r_enable;
        w_add = (r_pos == 2'd3) && (r_cnt < fpim_pkg::CNT_W'(fpim_pkg::MAX_SETS));
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            fpim_pkg::ST_ACC:    if (w_acc && s_axis_tlast) n_st = fpim_pkg::ST_LAUNCH;
            fpim_pkg::ST_LAUNCH: n_st = (r_cnt == '0) ? fpim_pkg::ST_ACC : fpim_pkg::ST_LANE;
            fpim_pkg::ST_LANE:   if (w_done_c && w_done_v) n_st = fpim_pkg::ST_MERGE;
            fpim_pkg::ST_MERGE:  if (w_mdone) n_st = fpim_pkg::ST_HOLD;
            fpim_pkg::ST_HOLD:   if (w_load) n_st = fpim_pkg::ST_ACC;
            default:             n_st = fpim_pkg::ST_ACC;
        endcase
    end

    always_comb begin
        s_axis_tready   = (r_st == fpim_pkg::ST_ACC);
        w_ctl.sample_en = w_acc;
        w_ctl.pos       = r_pos;
        w_ctl.add_set   = w_add;
        w_ctl.clear     = (r_st == fpim_pkg::ST_LAUNCH);
        w_ctl.start     = (r_st == fpim_pkg::ST_LAUNCH) && (r_cnt != '0);
        w_mstart        = (r_st == fpim_pkg::ST_LANE) && w_done_c && w_done_v;
        w_load          = (r_st == fpim_pkg::ST_HOLD) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= fpim_pkg::ST_ACC;
            r_enable    <= 1'b0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (w_ctl.clear) begin
                r_pos <= '0;
                r_cnt <= '0;
            end else if (w_acc) begin
                r_pos <= r_pos + 2'd1;
                if (w_add) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mag   <= w_mag;
            r_phase <= w_phase;
        end
    end

    fpim_lane u_lane_cur (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_sample    (s_axis_tdata[11:0]),
        .i_set_count (r_cnt),
        .o_done      (w_done_c),
        .o_res       (w_res_c)
    );

    fpim_lane u_lane_vol (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_sample    (s_axis_tdata[23:12]),
        .i_set_count (r_cnt),
        .o_done      (w_done_v),
        .o_res       (w_res_v)
    );

    fpim_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_cur   (w_res_c),
        .i_vol   (w_res_v),
        .o_done  (w_mdone),
        .o_mag   (w_mag),
        .o_phase (w_phase)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_phase, r_mag};

endmodule
